// File: hdl/pns_pkg.sv
// Shared constants, field widths and controller/datapath interface types for the scheduler.
package pns_pkg;

   localparam int MAX_PROCS_DEF = 64;
   localparam int TIME_BITS_DEF = 16;
   localparam int PRIO_BITS_DEF = 8;

   localparam int ARRIVAL_BITS  = 16;
   localparam int BURST_BITS    = 16;
   localparam int PRIO_FLD_BITS = 8;
   localparam int INDEX_BITS    = 6;
   localparam int RES_BITS      = 23;

   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 56;

   localparam logic [RES_BITS-1:0] RES_MAX = {RES_BITS{1'b1}};

   typedef struct packed {
      logic load;
      logic scan_init;
      logic scan_step;
      logic decide;
      logic out_init;
      logic out_load;
      logic batch_clear;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic found;
      logic all_done;
      logic out_free;
      logic out_last;
   } status_type;

endpackage

// File: hdl/pns_ctrl.sv
// Controller state machine: load, scan, pick and result sequencing.
module pns_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tlast,
   output logic                  req_tready,
   input  pns_pkg::status_type   status,
   output pns_pkg::cmd_type      cmd
);

   typedef enum logic [5:0] {
      ST_LOAD      = 6'b000001,
      ST_SCAN      = 6'b000010,
      ST_SCAN_TAIL = 6'b000100,
      ST_DECIDE    = 6'b001000,
      ST_OUT_RD    = 6'b010000,
      ST_OUT_LD    = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_LOAD);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tlast) begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_SCAN_TAIL;
            end
         end
         // last compare lands in the best-so-far registers this cycle
         ST_SCAN_TAIL: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (status.found && status.all_done) begin
               cmd.out_init = 1'b1;
               state_in     = ST_OUT_RD;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.out_last) begin
                  cmd.batch_clear = 1'b1;
                  state_in        = ST_LOAD;
               end else begin
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

// File: hdl/pns_datapath.sv
// Datapath: process stores, scan compare, simulated time and result register.
module pns_datapath #(
   parameter int MAX_PROCS = pns_pkg::MAX_PROCS_DEF,
   parameter int TIME_BITS = pns_pkg::TIME_BITS_DEF,
   parameter int PRIO_BITS = pns_pkg::PRIO_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pns_pkg::cmd_type                   cmd,
   output pns_pkg::status_type                status,
   input  logic [pns_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pns_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                               rsp_tuser,
   output logic                               rsp_tlast
);

   localparam int IDX_BITS = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_BITS = $clog2(MAX_PROCS + 1);
   // arrival plus all bursts stays below (MAX_PROCS + 1) * 2^TIME_BITS
   localparam int CLK_BITS = TIME_BITS + IDX_BITS + 1;
   localparam int SUM_BITS = CLK_BITS + 1;
   localparam int EXT_BITS = (SUM_BITS > pns_pkg::RES_BITS) ? SUM_BITS : pns_pkg::RES_BITS;
   localparam int RES_BITS = pns_pkg::RES_BITS;

   // stores
   logic [TIME_BITS-1:0] arr_mem   [MAX_PROCS];
   logic [TIME_BITS-1:0] burst_mem [MAX_PROCS];
   logic [PRIO_BITS-1:0] prio_mem  [MAX_PROCS];
   logic [CLK_BITS-1:0]  wait_mem  [MAX_PROCS];

   logic [TIME_BITS-1:0] rd_arr_ff;
   logic [TIME_BITS-1:0] rd_burst_ff;
   logic [PRIO_BITS-1:0] rd_prio_ff;
   logic [CLK_BITS-1:0]  rd_wait_ff;

   logic [MAX_PROCS-1:0] done_ff,     done_in;
   logic [CNT_BITS-1:0]  loaded_ff,   loaded_in;
   logic [CNT_BITS-1:0]  finished_ff, finished_in;
   logic                 ovf_ff,      ovf_in;
   logic [CLK_BITS-1:0]  now_ff,      now_in;
   logic [IDX_BITS-1:0]  idx_ff,      idx_in;
   logic                 cmp_vld_ff;
   logic [IDX_BITS-1:0]  cmp_idx_ff;

   logic                 found_ff,      found_in;
   logic [PRIO_BITS-1:0] best_prio_ff,  best_prio_in;
   logic [IDX_BITS-1:0]  best_idx_ff,   best_idx_in;
   logic [TIME_BITS-1:0] best_arr_ff,   best_arr_in;
   logic [TIME_BITS-1:0] best_burst_ff, best_burst_in;
   logic [TIME_BITS-1:0] next_arr_ff,   next_arr_in;

   logic                 out_vld_ff,  out_vld_in;
   logic [pns_pkg::INDEX_BITS-1:0] out_idx_ff;
   logic [RES_BITS-1:0]  out_wait_ff;
   logic [RES_BITS-1:0]  out_turn_ff;
   logic                 out_ovf_ff;
   logic                 out_last_ff;

   logic                 has_room;
   logic [IDX_BITS-1:0]  wr_idx;
   logic [TIME_BITS-1:0] req_arr;
   logic [TIME_BITS-1:0] req_burst;
   logic [PRIO_BITS-1:0] req_prio;
   logic                 idx_is_last;
   logic                 pending;
   logic                 arrived;
   logic [CLK_BITS-1:0]  wait_val;
   logic [EXT_BITS-1:0]  wait_ext;
   logic [EXT_BITS-1:0]  turn_ext;
   logic [EXT_BITS-1:0]  max_ext;
   logic [RES_BITS-1:0]  wait_sat;
   logic [RES_BITS-1:0]  turn_sat;

   assign has_room  = (loaded_ff < CNT_BITS'(MAX_PROCS));
   assign wr_idx    = loaded_ff[IDX_BITS-1:0];
   assign req_arr   = TIME_BITS'(req_tdata[15:0]);
   assign req_burst = TIME_BITS'(req_tdata[31:16]);
   assign req_prio  = PRIO_BITS'(req_tdata[39:32]);

   assign idx_is_last = ((CNT_BITS'(idx_ff) + CNT_BITS'(1)) == loaded_ff);

   always_ff @(posedge clock) begin
      if (cmd.load && has_room) begin
         arr_mem[wr_idx]   <= req_arr;
         burst_mem[wr_idx] <= req_burst;
         prio_mem[wr_idx]  <= req_prio;
      end
      rd_arr_ff   <= arr_mem[idx_ff];
      rd_burst_ff <= burst_mem[idx_ff];
      rd_prio_ff  <= prio_mem[idx_ff];
   end

   assign wait_val = now_ff - CLK_BITS'(best_arr_ff);

   always_ff @(posedge clock) begin
      if (cmd.decide && found_ff) begin
         wait_mem[best_idx_ff] <= wait_val;
      end
      rd_wait_ff <= wait_mem[idx_ff];
   end

   // scan compare, one entry per cycle behind the read
   assign pending = cmp_vld_ff && !done_ff[cmp_idx_ff];
   assign arrived = (CLK_BITS'(rd_arr_ff) <= now_ff);

   always_comb begin
      found_in      = found_ff;
      best_prio_in  = best_prio_ff;
      best_idx_in   = best_idx_ff;
      best_arr_in   = best_arr_ff;
      best_burst_in = best_burst_ff;
      next_arr_in   = next_arr_ff;
      if (cmd.scan_init) begin
         found_in    = 1'b0;
         next_arr_in = {TIME_BITS{1'b1}};
      end else if (pending) begin
         if (arrived) begin
            if (!found_ff || (rd_prio_ff < best_prio_ff)) begin
               found_in      = 1'b1;
               best_prio_in  = rd_prio_ff;
               best_idx_in   = cmp_idx_ff;
               best_arr_in   = rd_arr_ff;
               best_burst_in = rd_burst_ff;
            end
         end else if (rd_arr_ff < next_arr_ff) begin
            next_arr_in = rd_arr_ff;
         end
      end
   end

   always_comb begin
      done_in     = done_ff;
      loaded_in   = loaded_ff;
      finished_in = finished_ff;
      ovf_in      = ovf_ff;
      now_in      = now_ff;
      idx_in      = idx_ff;
      if (cmd.load) begin
         if (has_room) begin
            loaded_in = loaded_ff + CNT_BITS'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.decide) begin
         if (found_ff) begin
            now_in               = now_ff + CLK_BITS'(best_burst_ff);
            done_in[best_idx_ff] = 1'b1;
            finished_in          = finished_ff + CNT_BITS'(1);
         end else begin
            now_in = CLK_BITS'(next_arr_ff);
         end
      end
      if (cmd.scan_init || cmd.out_init) begin
         idx_in = '0;
      end else if ((cmd.scan_step || cmd.out_load) && !idx_is_last) begin
         idx_in = idx_ff + IDX_BITS'(1);
      end
      if (cmd.batch_clear) begin
         done_in     = '0;
         loaded_in   = '0;
         finished_in = '0;
         ovf_in      = 1'b0;
         now_in      = '0;
      end
   end

   // result register
   assign wait_ext = EXT_BITS'(rd_wait_ff);
   assign turn_ext = EXT_BITS'(SUM_BITS'(rd_wait_ff) + SUM_BITS'(rd_burst_ff));
   assign max_ext  = EXT_BITS'(pns_pkg::RES_MAX);
   assign wait_sat = (wait_ext > max_ext) ? pns_pkg::RES_MAX : wait_ext[RES_BITS-1:0];
   assign turn_sat = (turn_ext > max_ext) ? pns_pkg::RES_MAX : turn_ext[RES_BITS-1:0];

   assign out_vld_in = cmd.out_load || (out_vld_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_idx_ff  <= pns_pkg::INDEX_BITS'(idx_ff);
         out_wait_ff <= wait_sat;
         out_turn_ff <= turn_sat;
         out_ovf_ff  <= ovf_ff;
         out_last_ff <= idx_is_last;
      end
      best_prio_ff  <= best_prio_in;
      best_idx_ff   <= best_idx_in;
      best_arr_ff   <= best_arr_in;
      best_burst_ff <= best_burst_in;
      next_arr_ff   <= next_arr_in;
      cmp_idx_ff    <= idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff     <= '0;
         loaded_ff   <= '0;
         finished_ff <= '0;
         ovf_ff      <= 1'b0;
         now_ff      <= '0;
         idx_ff      <= '0;
         cmp_vld_ff  <= 1'b0;
         found_ff    <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         done_ff     <= done_in;
         loaded_ff   <= loaded_in;
         finished_ff <= finished_in;
         ovf_ff      <= ovf_in;
         now_ff      <= now_in;
         idx_ff      <= idx_in;
         cmp_vld_ff  <= cmd.scan_step;
         found_ff    <= found_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   assign status.scan_last = idx_is_last;
   assign status.found     = found_ff;
   assign status.all_done  = ((finished_ff + CNT_BITS'(1)) == loaded_ff);
   assign status.out_free  = !out_vld_ff || rsp_tready;
   assign status.out_last  = idx_is_last;

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {4'b0, out_turn_ff, out_wait_ff, out_idx_ff};
   assign rsp_tuser  = out_ovf_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// File: hdl/priority_nonpreemptive_scheduler_top.sv
// Top level: non-preemptive priority scheduler, controller plus datapath.
// Load: one word per cycle. Each pick scans the N loaded entries, one per cycle, then
// goes through the scan tail and decide states; an idle jump to the next arrival costs
// one extra scan. A batch of N takes at most N loads and 2N scans; then each result word
// goes through a memory read, then the output register, which waits on a stalled receiver.
// Synchronous active-high reset clears the batch count, time, done flags and output valid.
module priority_nonpreemptive_scheduler_top #(
   parameter int MAX_PROCS = pns_pkg::MAX_PROCS_DEF,
   parameter int TIME_BITS = pns_pkg::TIME_BITS_DEF,
   parameter int PRIO_BITS = pns_pkg::PRIO_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // arrival [15:0], burst [31:16], priority_level [39:32]
   input  logic [pns_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                               req_tlast,   // last_proc
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // proc_index [5:0], waiting [28:6], turnaround [51:29], zero fill [55:52]
   output logic [pns_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                               rsp_tuser,   // overflow
   output logic                               rsp_tlast    // last_result
);

   pns_pkg::cmd_type    cmd;
   pns_pkg::status_type status;

   pns_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pns_datapath #(
      .MAX_PROCS (MAX_PROCS),
      .TIME_BITS (TIME_BITS),
      .PRIO_BITS (PRIO_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // a result word must never overwrite one still waiting
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded over pending word");

   // batch clears only with the final result word
   a_clear_last: assert property (@(posedge clock) disable iff (reset)
      cmd.batch_clear |-> (cmd.out_load && status.out_last))
      else $error("batch cleared before final result");

   // scan and result sequencing never overlap
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.scan_init, cmd.scan_step, cmd.out_init, cmd.out_load}))
      else $error("conflicting datapath commands");

   // a pick is decided only after the scan's final issue and the scan tail state
   a_decide_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |-> $past(cmd.scan_step, 2))
      else $error("decide without completed scan");

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the non-preemptive priority scheduler top level.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPROC        = pns_pkg::MAX_PROCS_DEF;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 50;
   localparam int PHASE_WORDS  = 78;

   typedef struct {
      bit [pns_pkg::ARRIVAL_BITS-1:0]  arrival;
      bit [pns_pkg::BURST_BITS-1:0]    burst;
      bit [pns_pkg::PRIO_FLD_BITS-1:0] prio;
      bit                              last;
   } proc_word_type;

   typedef struct {
      bit [pns_pkg::INDEX_BITS-1:0] proc_index;
      bit [pns_pkg::RES_BITS-1:0]   waiting;
      bit [pns_pkg::RES_BITS-1:0]   turnaround;
      bit                           overflow;
      bit                           last_result;
   } sched_result_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [pns_pkg::REQ_DATA_BITS-1:0] req_tdata;
   logic                              req_tlast;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [pns_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                              rsp_tuser;
   logic                              rsp_tlast;

   priority_nonpreemptive_scheduler_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   // scheduler shadow state
   bit [pns_pkg::ARRIVAL_BITS-1:0]  arrival_mem [NPROC];
   bit [pns_pkg::BURST_BITS-1:0]    burst_mem   [NPROC];
   bit [pns_pkg::PRIO_FLD_BITS-1:0] prio_mem    [NPROC];
   int                              loaded_procs;
   bit                              batch_overflow;
   sched_result_type                expected_sched [$];

   int send_idle_pct;
   int recv_stall_pct;
   int mismatches;
   int cycle_count;
   int words_sent;

   function automatic bit [pns_pkg::RES_BITS-1:0] clamp_res(longint v);
      return (v > longint'(pns_pkg::RES_MAX)) ? pns_pkg::RES_MAX : v[pns_pkg::RES_BITS-1:0];
   endfunction

   // Loads one word; on the closing word runs the whole batch and queues its results.
   function automatic void record_process(proc_word_type w);
      longint           now;
      longint           next_arr;
      longint           wait_t [NPROC];
      bit               done   [NPROC];
      int               finished;
      int               pick;
      sched_result_type r;
      if (loaded_procs < NPROC) begin
         arrival_mem[loaded_procs] = w.arrival;
         burst_mem[loaded_procs]   = w.burst;
         prio_mem[loaded_procs]    = w.prio;
         loaded_procs++;
      end else begin
         batch_overflow = 1'b1;
      end
      if (!w.last) return;
      now      = 0;
      finished = 0;
      while (finished < loaded_procs) begin
         pick     = -1;
         next_arr = 64'h7fff_ffff_ffff_ffff;
         for (int i = 0; i < loaded_procs; i++) begin
            if (done[i]) continue;
            if (longint'(arrival_mem[i]) <= now) begin
               if (pick < 0 || prio_mem[i] < prio_mem[pick]) pick = i;
            end else if (longint'(arrival_mem[i]) < next_arr) begin
               next_arr = longint'(arrival_mem[i]);
            end
         end
         if (pick < 0) begin
            now = next_arr;   // nothing has arrived: jump ahead
         end else begin
            wait_t[pick] = now - longint'(arrival_mem[pick]);
            now += longint'(burst_mem[pick]);
            done[pick] = 1'b1;
            finished++;
         end
      end
      for (int i = 0; i < loaded_procs; i++) begin
         r.proc_index  = i[pns_pkg::INDEX_BITS-1:0];
         r.waiting     = clamp_res(wait_t[i]);
         r.turnaround  = clamp_res(wait_t[i] + longint'(burst_mem[i]));
         r.overflow    = batch_overflow;
         r.last_result = (i == loaded_procs - 1);
         expected_sched.push_back(r);
      end
      loaded_procs   = 0;
      batch_overflow = 1'b0;
   endfunction

   task automatic send_proc(input bit [pns_pkg::ARRIVAL_BITS-1:0] arrival,
                            input bit [pns_pkg::BURST_BITS-1:0] burst,
                            input bit [pns_pkg::PRIO_FLD_BITS-1:0] prio, input bit last);
      proc_word_type w;
      w.arrival = arrival;
      w.burst   = burst;
      w.prio    = prio;
      w.last    = last;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {prio, burst, arrival};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      record_process(w);
      words_sent++;
   endtask

   task automatic release_req();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_results_drained();
      while (expected_sched.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // style 0: heavy contention and ties, 1: full-range fields, 2: spread arrivals
   task automatic send_random_batch(input int n, input int style);
      bit [pns_pkg::ARRIVAL_BITS-1:0]  a;
      bit [pns_pkg::BURST_BITS-1:0]    b;
      bit [pns_pkg::PRIO_FLD_BITS-1:0] p;
      for (int i = 0; i < n; i++) begin
         case (style)
            0: begin
               a = pns_pkg::ARRIVAL_BITS'($urandom_range(0, 30));
               b = pns_pkg::BURST_BITS'($urandom_range(0, 15));
               p = pns_pkg::PRIO_FLD_BITS'($urandom_range(0, 3));
            end
            1: begin
               a = pns_pkg::ARRIVAL_BITS'($urandom_range(0, 65535));
               b = pns_pkg::BURST_BITS'($urandom_range(0, 65535));
               p = pns_pkg::PRIO_FLD_BITS'($urandom_range(0, 255));
            end
            default: begin
               a = pns_pkg::ARRIVAL_BITS'($urandom_range(0, 400));
               b = pns_pkg::BURST_BITS'($urandom_range(0, 40));
               p = pns_pkg::PRIO_FLD_BITS'($urandom_range(0, 255));
            end
         endcase
         send_proc(a, b, p, i == n - 1);
      end
   endtask

   task automatic test_extremes();
      set_idling(0, 0);
      send_proc(16'd0, 16'd0, 8'd0, 1'b1);
      send_proc(16'hffff, 16'hffff, 8'hff, 1'b1);
      send_proc(16'd0, 16'hffff, 8'hff, 1'b0);
      send_proc(16'd0, 16'hffff, 8'hff, 1'b0);
      send_proc(16'hffff, 16'hffff, 8'd0, 1'b1);
   endtask

   task automatic test_priority_ties();
      send_proc(16'd0, 16'd3, 8'd7, 1'b0);
      send_proc(16'd0, 16'd0, 8'd7, 1'b0);
      send_proc(16'd0, 16'd5, 8'd7, 1'b0);
      send_proc(16'd0, 16'd1, 8'd7, 1'b1);
   endtask

   // long low-priority job runs to the end; later idle gap forces a time jump
   task automatic test_nonpreempt_gap();
      send_proc(16'd0, 16'd10, 8'd9, 1'b0);
      send_proc(16'd1, 16'd2, 8'd0, 1'b0);
      send_proc(16'd2, 16'd4, 8'd0, 1'b0);
      send_proc(16'd3, 16'd0, 8'd255, 1'b0);
      send_proc(16'd500, 16'd7, 8'd1, 1'b0);
      send_proc(16'd500, 16'd2, 8'd1, 1'b1);
   endtask

   task automatic test_drain_pause();
      set_idling(15, 15);
      send_random_batch(5, 0);
      release_req();
      wait_results_drained();
      send_random_batch(3, 2);
   endtask

   task automatic test_full_batch();
      set_idling(0, 48);
      send_random_batch(NPROC, 0);
   endtask

   // words past capacity are dropped, the closing word among them
   task automatic test_overflow();
      set_idling(15, 15);
      send_random_batch(NPROC + 3, 2);
   endtask

   task automatic test_random_batches();
      int n;
      int start;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       set_idling(0, 0);
            1:       set_idling(48, 0);
            2:       set_idling(0, 48);
            default: set_idling(15, 15);
         endcase
         start = words_sent;
         while (words_sent - start < PHASE_WORDS) begin
            n = ($urandom_range(11) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            send_random_batch(n, $urandom_range(0, 2));
         end
      end
   endtask

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("priority_nonpreemptive_scheduler_top test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      sched_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_sched.size() == 0) begin
            $error("unexpected result word: proc_index=%0d", rsp_tdata[5:0]);
            mismatches++;
         end else begin
            exp_r = expected_sched.pop_front();
            if (rsp_tdata[5:0] !== exp_r.proc_index) begin
               $error("proc_index: expected %0d, got %0d", exp_r.proc_index, rsp_tdata[5:0]);
               mismatches++;
            end
            if (rsp_tdata[28:6] !== exp_r.waiting) begin
               $error("waiting: expected %0d, got %0d", exp_r.waiting, rsp_tdata[28:6]);
               mismatches++;
            end
            if (rsp_tdata[51:29] !== exp_r.turnaround) begin
               $error("turnaround: expected %0d, got %0d", exp_r.turnaround,
                      rsp_tdata[51:29]);
               mismatches++;
            end
            if (rsp_tuser !== exp_r.overflow) begin
               $error("overflow: expected %0d, got %0d", exp_r.overflow, rsp_tuser);
               mismatches++;
            end
            if (rsp_tlast !== exp_r.last_result) begin
               $error("last_result: expected %0d, got %0d", exp_r.last_result, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      loaded_procs   = 0;
      batch_overflow = 1'b0;
      mismatches     = 0;
      cycle_count    = 0;
      words_sent     = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extremes();
      test_priority_ties();
      test_nonpreempt_gap();
      test_drain_pause();
      test_full_batch();
      test_overflow();
      test_random_batches();

      release_req();
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_sched.size() == 0) begin
         $display("priority_nonpreemptive_scheduler_top test passed");
      end else begin
         $display("priority_nonpreemptive_scheduler_top test failed");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/pns_pkg.sv
hdl/pns_ctrl.sv
hdl/pns_datapath.sv
hdl/priority_nonpreemptive_scheduler_top.sv
dv/tb_top.sv
